[rtl/core/wsfe_pkg.sv]
`default_nettype none

package wsfe_pkg;

    // Fixed header codes of a masked client text frame.
    localparam logic [7:0] FIRST_BYTE  = 8'd129;
    localparam logic [7:0] SHORT_MAX   = 8'd125;
    localparam logic [7:0] LEN16_CODE  = 8'd126;
    localparam logic [7:0] LEN64_CODE  = 8'd127;
    localparam logic [7:0] MASK_BIT    = 8'd128;

    // Queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Kind of an input word as carried on tuser.
    typedef enum logic {
        OP_START   = 1'b0,
        OP_PAYLOAD = 1'b1
    } wsfe_op_t;

    // Kind of a queued command.
    typedef enum logic {
        KIND_HEADER = 1'b0,
        KIND_DATA   = 1'b1
    } wsfe_kind_t;

    // Length coding of the header.
    typedef enum logic [1:0] {
        FORM_SHORT = 2'd0,
        FORM_MID   = 2'd1,
        FORM_LONG  = 2'd2
    } wsfe_form_t;

    // States of the back sequencer.
    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_HDR  = 1'b1
    } wsfe_bk_state_t;

    // One command handed from the front to the back.
    typedef struct packed {
        wsfe_kind_t  kind;
        wsfe_form_t  form;
        logic [31:0] len;
        logic [31:0] key;
        logic [7:0]  data;
        logic        last;
    } wsfe_cmd_t;

    // Queue fill status.
    typedef struct packed {
        logic full;
        logic empty;
    } wsfe_qstat_t;

    // Front status seen by the top level.
    typedef struct packed {
        logic push;
        logic frame_open;
    } wsfe_fstat_t;

    // Key byte at a position, bits 31:24 first.
    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/core/wsfe_front.sv]
`default_nettype none

module wsfe_front
    import wsfe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic        op,
    input  wire logic [31:0] payload_length,
    input  wire logic [31:0] mask_key,
    input  wire logic [7:0]  data_byte,
    output wsfe_cmd_t        cmd,
    output wsfe_fstat_t      stat
);

    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] key_store_reg, key_store_next;
    logic [1:0]  key_pos_reg, key_pos_next;
    logic        frame_open_reg, frame_open_next;
    logic [31:0] left_dec;
    logic        push;

    assign left_dec = bytes_left_reg - 32'd1;

    // Classify the word, build the command and advance the frame state.
    always_comb begin
        bytes_left_next = bytes_left_reg;
        key_store_next  = key_store_reg;
        key_pos_next    = key_pos_reg;
        frame_open_next = frame_open_reg;
        push            = 1'b0;
        cmd.kind        = KIND_DATA;
        cmd.form        = FORM_SHORT;
        cmd.len         = payload_length;
        cmd.key         = mask_key;
        cmd.data        = data_byte ^ key_byte(key_store_reg, key_pos_reg);
        cmd.last        = (left_dec == 32'd0);

        if (payload_length <= {24'd0, SHORT_MAX}) begin
            cmd.form = FORM_SHORT;
        end else if (payload_length[31:16] == 16'd0) begin
            cmd.form = FORM_MID;
        end else begin
            cmd.form = FORM_LONG;
        end

        if (op == OP_START) begin
            cmd.kind = KIND_HEADER;
            cmd.last = (payload_length == 32'd0);
        end

        if (accept) begin
            if (op == OP_START) begin
                push            = 1'b1;
                bytes_left_next = payload_length;
                key_store_next  = mask_key;
                key_pos_next    = 2'd0;
                frame_open_next = (payload_length != 32'd0);
            end else if (frame_open_reg) begin
                push            = 1'b1;
                bytes_left_next = left_dec;
                key_pos_next    = key_pos_reg + 2'd1;
                frame_open_next = (left_dec != 32'd0);
            end
        end
    end

    assign stat.push       = push;
    assign stat.frame_open = frame_open_reg;

    // Frame state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= 32'd0;
            key_store_reg  <= 32'd0;
            key_pos_reg    <= 2'd0;
            frame_open_reg <= 1'b0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            key_store_reg  <= key_store_next;
            key_pos_reg    <= key_pos_next;
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/wsfe_fifo.sv]
`default_nettype none

module wsfe_fifo
    import wsfe_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wsfe_cmd_t  push_cmd,
    input  wire logic  pop,
    output wsfe_cmd_t  pop_cmd,
    output wsfe_qstat_t stat
);

    wsfe_cmd_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    assign stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/core/wsfe_back.sv]
`default_nettype none

module wsfe_back
    import wsfe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wsfe_cmd_t        cmd,
    input  wsfe_qstat_t      qstat,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    wsfe_bk_state_t state_reg, state_next;
    logic [3:0]     step_reg, step_next;
    wsfe_form_t     form_reg, form_next;
    logic [31:0]    len_reg, len_next;
    logic [31:0]    key_reg, key_next;
    logic           empty_frame_reg, empty_frame_next;
    logic           valid_reg, valid_next;
    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic           out_free;
    logic [3:0]     key_start;
    logic [1:0]     key_off;
    logic [7:0]     hdr_byte;

    assign out_free = !valid_reg || m_tready;

    // First key byte position for each length coding.
    always_comb begin
        case (form_reg)
            FORM_SHORT: key_start = 4'd2;
            FORM_MID:   key_start = 4'd4;
            default:    key_start = 4'd10;
        endcase
    end

    // Only the key byte index modulo four matters.
    assign key_off = step_reg[1:0] - key_start[1:0];

    // Header byte at the current step (steps past the first byte).
    always_comb begin
        hdr_byte = 8'd0;
        if (step_reg == 4'd1) begin
            case (form_reg)
                FORM_SHORT: hdr_byte = MASK_BIT | {1'b0, len_reg[6:0]};
                FORM_MID:   hdr_byte = MASK_BIT | LEN16_CODE;
                default:    hdr_byte = MASK_BIT | LEN64_CODE;
            endcase
        end else if (step_reg < key_start) begin
            if (form_reg == FORM_MID) begin
                hdr_byte = (step_reg == 4'd2) ? len_reg[15:8] : len_reg[7:0];
            end else begin
                case (step_reg)
                    4'd6:    hdr_byte = len_reg[31:24];
                    4'd7:    hdr_byte = len_reg[23:16];
                    4'd8:    hdr_byte = len_reg[15:8];
                    4'd9:    hdr_byte = len_reg[7:0];
                    default: hdr_byte = 8'd0;
                endcase
            end
        end else begin
            hdr_byte = key_byte(key_reg, key_off);
        end
    end

    // Sequencer: pops commands and drives the output register.
    always_comb begin
        state_next       = state_reg;
        step_next        = step_reg;
        form_next        = form_reg;
        len_next         = len_reg;
        key_next         = key_reg;
        empty_frame_next = empty_frame_reg;
        valid_next       = valid_reg && !m_tready;
        byte_next        = byte_reg;
        last_next        = last_reg;
        pop              = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (out_free && !qstat.empty) begin
                    pop        = 1'b1;
                    valid_next = 1'b1;
                    if (cmd.kind == KIND_DATA) begin
                        byte_next = cmd.data;
                        last_next = cmd.last;
                    end else begin
                        byte_next        = FIRST_BYTE;
                        last_next        = 1'b0;
                        form_next        = cmd.form;
                        len_next         = cmd.len;
                        key_next         = cmd.key;
                        empty_frame_next = cmd.last;
                        step_next        = 4'd1;
                        state_next       = BK_HDR;
                    end
                end
            end
            BK_HDR: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    byte_next  = hdr_byte;
                    last_next  = 1'b0;
                    step_next  = step_reg + 4'd1;
                    if (step_reg == key_start + 4'd3) begin
                        last_next  = empty_frame_reg;
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            step_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        form_reg        <= form_next;
        len_reg         <= len_next;
        key_reg         <= key_next;
        empty_frame_reg <= empty_frame_next;
        byte_reg        <= byte_next;
        last_reg        <= last_next;
    end

endmodule

`default_nettype wire

[rtl/core/websocket_client_frame_encoder_unit.sv]
`default_nettype none

// Channel  Direction  tdata (low bit up)                                  tuser / tlast
// s_       in         payload_length[31:0], mask_key[63:32],              tuser: op
//                     data_byte[71:64], zero pad [79:72]
// m_       out        out_byte[7:0]                                       tlast: frame_end
//
// A taken payload word is queued, then registered into the m_ output byte register.
// A start word makes the back sequencer send 6, 8 or 14 header bytes, one per cycle
// while m_tready is high; the next command follows the last header byte with no gap.
// The four-entry command queue lets input continue while the header is sent.
// Synchronous active-low reset empties the queue and closes any open frame.
// A payload word with no open frame is taken and dropped.

module websocket_client_frame_encoder_unit
    import wsfe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,  // payload_length, mask_key, data_byte, pad
    input  wire logic        s_tuser,  // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // out_byte
    output logic             m_tlast
);

    wsfe_cmd_t   push_cmd;
    wsfe_cmd_t   pop_cmd;
    wsfe_qstat_t qstat;
    wsfe_fstat_t fstat;
    logic        pop;
    logic        accept;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;

    // Front: takes words and classifies them.
    wsfe_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .op             (s_tuser),
        .payload_length (s_tdata[31:0]),
        .mask_key       (s_tdata[63:32]),
        .data_byte      (s_tdata[71:64]),
        .cmd            (push_cmd),
        .stat           (fstat)
    );

    // Command queue.
    wsfe_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fstat.push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (qstat)
    );

    // Back: sequences header and payload bytes onto the output.
    wsfe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (pop_cmd),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The queue is never written when full nor read when empty.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fstat.push |-> !qstat.full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !qstat.empty)
        else $error("command queue read while empty");

    // A payload word with no open frame leaves no command behind.
    a_drop_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == OP_PAYLOAD && !fstat.frame_open) |-> !fstat.push)
        else $error("orphan payload word was queued");

    // Reset leaves the output empty.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid straight after reset");

endmodule

`default_nettype wire
